[hdl/mono_framebuffer_dirty_line_pacer_macros.svh]
// Assertion macros for the frame buffer pacer RTL
// Each use needs clk and arst_n in scope; the macros expand to nothing under SYNTHESIS
`ifndef MONO_FRAMEBUFFER_DIRTY_LINE_PACER_MACROS_SVH
`define MONO_FRAMEBUFFER_DIRTY_LINE_PACER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off during reset
`define MFDLP_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfdlp: same-cycle check failed");
// next-cycle implication, off during reset
`define MFDLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfdlp: next-cycle check failed");
`else
`define MFDLP_ASSERT_IMPLIES(label, ante, cons)
`define MFDLP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/mfdlp_pkg.sv]
// Shared types, codes and constants of the frame buffer pacer
// No dependencies; used by every module of the block but mfdlp_ram
package mfdlp_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_TICK   = 2'd2,
		OP_REDRAW = 2'd3
	} op_t;

	// access size codes, anything else is a word
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	// fixed field widths
	localparam int ADDR_W     = 18;
	localparam int DATA_W     = 32;
	localparam int COUNT_W    = 16;
	localparam int RATE_W     = 27;
	localparam int LINE_OUT_W = 10;
	localparam int ACC_W      = 32;

	localparam logic [RATE_W-1:0] RATE_RESET = 27'd1000000;

	// register indexes on the configuration bus
	localparam logic REG_CLOCK_RATE = 1'b0;
	localparam logic REG_DISPLAY    = 1'b1;

	// configuration state and write side effects
	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              attached;
		logic              clear_acc;
		logic              mark_all;
	} cfg_t;

	// pipeline advance strobes
	typedef struct packed {
		logic adv2;
		logic adv3;
	} pipe_ctl_t;

	// frame update produced by a tick
	typedef struct packed {
		logic                  valid;
		logic [LINE_OUT_W-1:0] first_line;
		logic [LINE_OUT_W-1:0] line_count;
	} flush_t;

	// bytes in an access minus one
	function automatic logic [1:0] size_span(input logic [1:0] size);
		logic [1:0] span;
		case (size)
			SIZE_BYTE: span = 2'd0;
			SIZE_HALF: span = 2'd1;
			default:   span = 2'd3;
		endcase
		return span;
	endfunction

endpackage

[hdl/mfdlp_ram.sv]
// Generic single-port RAM with registered read
// No dependencies
module mfdlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[hdl/mfdlp_vram.sv]
// Video RAM as four byte-lane banks: lane steering, wrap and big-endian assembly
// Depends on mfdlp_pkg and mfdlp_ram
module mfdlp_vram #(
	parameter int RAM_BYTES = 262144
) (
	input  logic                           clk,
	input  logic                           en,
	input  mfdlp_pkg::op_t                 op_s1,
	input  logic [mfdlp_pkg::ADDR_W-1:0]   addr_s1,
	input  logic [1:0]                     size_s1,
	input  logic [mfdlp_pkg::DATA_W-1:0]   data_s1,
	input  mfdlp_pkg::op_t                 op_s2,
	input  logic [1:0]                     lo_s2,
	input  logic [1:0]                     size_s2,
	output logic [mfdlp_pkg::DATA_W-1:0]   rd_data
);

	localparam int ROWS   = RAM_BYTES / 4;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int BASE_W = mfdlp_pkg::ADDR_W - 1;
	localparam int CMP_W  = ($clog2(ROWS + 1) > BASE_W) ? $clog2(ROWS + 1) : BASE_W;

	logic [1:0]        lo;
	logic [1:0]        span;
	logic [BASE_W-1:0] base_lo;
	logic [BASE_W-1:0] base_hi;
	logic [ROW_W-1:0]  row_lo;
	logic [ROW_W-1:0]  row_hi;
	logic [1:0]        k_b    [4];
	logic [1:0]        idx_b  [4];
	logic              we_b   [4];
	logic [ROW_W-1:0]  row_b  [4];
	logic [7:0]        wbyte_b[4];
	logic [7:0]        q_b    [4];
	logic [7:0]        rbyte  [4];
	logic [1:0]        sel_k  [4];

	// row index modulo the bank depth, input is below twice the depth
	function automatic logic [ROW_W-1:0] wrap_row(input logic [BASE_W-1:0] r);
		logic [CMP_W-1:0] w;
		w = CMP_W'(r);
		if (w >= CMP_W'(ROWS)) begin
			w = w - CMP_W'(ROWS);
		end
		return w[ROW_W-1:0];
	endfunction

	// rows touched by the access: lanes below the start lane sit one row on
	assign lo      = addr_s1[1:0];
	assign span    = mfdlp_pkg::size_span(size_s1);
	assign base_lo = {1'b0, addr_s1[mfdlp_pkg::ADDR_W-1:2]};
	assign base_hi = base_lo + BASE_W'(1);
	assign row_lo  = wrap_row(base_lo);
	assign row_hi  = wrap_row(base_hi);

	// per-lane byte position, address, enable and write byte
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			k_b[b]     = 2'(b) - lo;
			idx_b[b]   = span - k_b[b];
			row_b[b]   = (2'(b) < lo) ? row_hi : row_lo;
			wbyte_b[b] = data_s1[{idx_b[b], 3'b000} +: 8];
			we_b[b]    = en && (op_s1 == mfdlp_pkg::OP_WRITE) && (k_b[b] <= span);
		end
	end

	// byte-lane banks
	for (genvar g = 0; g < 4; g++) begin : g_bank
		mfdlp_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we_b[g]),
			.re   (en),
			.addr (row_b[g]),
			.wdata(wbyte_b[g]),
			.rdata(q_b[g])
		);
	end

	// big-endian assembly of the registered lanes
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sel_k[k] = lo_s2 + 2'(k);
			rbyte[k] = q_b[sel_k[k]];
		end
		case (size_s2)
			mfdlp_pkg::SIZE_BYTE: rd_data = {24'd0, rbyte[0]};
			mfdlp_pkg::SIZE_HALF: rd_data = {16'd0, rbyte[0], rbyte[1]};
			default:              rd_data = {rbyte[0], rbyte[1], rbyte[2], rbyte[3]};
		endcase
		if (op_s2 != mfdlp_pkg::OP_READ) begin
			rd_data = '0;
		end
	end

endmodule

[hdl/mfdlp_pacer.sv]
// Dirty line tracker and frame pacer: line numbers, tick accumulator, flush decision
// Depends on mfdlp_pkg and the assertion macro header
`include "mono_framebuffer_dirty_line_pacer_macros.svh"

module mfdlp_pacer #(
	parameter int SCREEN_WIDTH  = 1280,
	parameter int SCREEN_HEIGHT = 960,
	parameter int FRAME_RATE    = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mfdlp_pkg::pipe_ctl_t            ctl,
	input  mfdlp_pkg::cfg_t                 cfg,
	input  logic [mfdlp_pkg::ADDR_W-1:0]    addr_s1,
	input  logic [1:0]                      size_s1,
	input  logic [mfdlp_pkg::COUNT_W-1:0]   count_s1,
	input  mfdlp_pkg::op_t                  op_s2,
	output mfdlp_pkg::flush_t               flush
);

	localparam int LINE_BYTES = SCREEN_WIDTH / 8;
	localparam int SPAN_W     = mfdlp_pkg::ADDR_W + 1;
	localparam int MAX_LINE   = (2 ** mfdlp_pkg::ADDR_W + 2) / LINE_BYTES;
	localparam int LINE_TOP   = (MAX_LINE > SCREEN_HEIGHT) ? MAX_LINE : SCREEN_HEIGHT;
	localparam int LINE_W     = $clog2(LINE_TOP + 1);
	localparam int EXT_W      = (LINE_W > mfdlp_pkg::LINE_OUT_W) ? LINE_W : mfdlp_pkg::LINE_OUT_W;
	localparam int DIV_L      = $clog2(LINE_BYTES);
	localparam int SHIFT      = SPAN_W + DIV_L;
	localparam int PROD_W     = SHIFT + LINE_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);
	localparam int INC_W      = mfdlp_pkg::COUNT_W + $clog2(FRAME_RATE + 1);
	localparam int ACC_W      = mfdlp_pkg::ACC_W;

	logic [SPAN_W-1:0] first_addr;
	logic [SPAN_W-1:0] last_addr;
	logic [PROD_W-1:0] prod_first;
	logic [PROD_W-1:0] prod_last;

	logic [LINE_W-1:0] y1_s2;
	logic [LINE_W-1:0] y2_s2;
	logic [INC_W-1:0]  inc_s2;

	logic              dirty_flag_q;
	logic [LINE_W-1:0] dirty_first_q;
	logic [LINE_W-1:0] dirty_last_q;
	logic [ACC_W-1:0]  acc_q;

	logic [ACC_W:0]    sum_full;
	logic [ACC_W-1:0]  sum_sat;
	logic [ACC_W-1:0]  rate_ext;
	logic              reach;
	logic [ACC_W-1:0]  after_sub;
	logic [LINE_W-1:0] last_clamp;
	logic [LINE_W-1:0] line_count;
	logic [EXT_W-1:0]  first_ext;
	logic [EXT_W-1:0]  count_ext;
	logic              on_screen;
	logic              fire;

	// line numbers by exact reciprocal multiply of first and unwrapped last byte
	assign first_addr = {1'b0, addr_s1};
	assign last_addr  = first_addr + SPAN_W'(mfdlp_pkg::size_span(size_s1));
	assign prod_first = PROD_W'(first_addr) * PROD_W'(RECIP);
	assign prod_last  = PROD_W'(last_addr) * PROD_W'(RECIP);

	// line and increment register
	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			y1_s2  <= prod_first[PROD_W-1:SHIFT];
			y2_s2  <= prod_last[PROD_W-1:SHIFT];
			inc_s2 <= INC_W'(count_s1) * INC_W'(FRAME_RATE);
		end
	end

	// saturating accumulate, threshold and subtract
	assign sum_full  = {1'b0, acc_q} + (ACC_W + 1)'(inc_s2);
	assign sum_sat   = sum_full[ACC_W] ? '1 : sum_full[ACC_W-1:0];
	assign rate_ext  = ACC_W'(cfg.rate);
	assign reach     = (sum_sat >= rate_ext);
	assign after_sub = sum_sat - rate_ext;

	// flush decision and line count with the last line clamped to the screen
	assign last_clamp = (dirty_last_q >= LINE_W'(SCREEN_HEIGHT)) ?
		LINE_W'(SCREEN_HEIGHT - 1) : dirty_last_q;
	assign line_count = last_clamp - dirty_first_q + LINE_W'(1);
	assign fire = (op_s2 == mfdlp_pkg::OP_TICK) && reach && cfg.attached && dirty_flag_q
		&& (dirty_first_q < LINE_W'(SCREEN_HEIGHT));
	assign first_ext = EXT_W'(dirty_first_q);
	assign count_ext = EXT_W'(line_count);
	assign on_screen = (y1_s2 < LINE_W'(SCREEN_HEIGHT));

	always_comb begin
		flush.valid      = fire;
		flush.first_line = fire ? first_ext[mfdlp_pkg::LINE_OUT_W-1:0] : '0;
		flush.line_count = fire ? count_ext[mfdlp_pkg::LINE_OUT_W-1:0] : '0;
	end

	// dirty range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_flag_q  <= 1'b1;
			dirty_first_q <= '0;
			dirty_last_q  <= LINE_W'(SCREEN_HEIGHT - 1);
		end else if (cfg.mark_all) begin
			dirty_flag_q  <= 1'b1;
			dirty_first_q <= '0;
			dirty_last_q  <= LINE_W'(SCREEN_HEIGHT - 1);
		end else if (ctl.adv3) begin
			case (op_s2)
				mfdlp_pkg::OP_WRITE: begin
					if (on_screen) begin
						if (!dirty_flag_q) begin
							dirty_flag_q  <= 1'b1;
							dirty_first_q <= y1_s2;
							dirty_last_q  <= y2_s2;
						end else begin
							if (y1_s2 < dirty_first_q) begin
								dirty_first_q <= y1_s2;
							end
							if (y2_s2 > dirty_last_q) begin
								dirty_last_q <= y2_s2;
							end
						end
					end
				end
				mfdlp_pkg::OP_TICK: begin
					if (fire) begin
						dirty_flag_q  <= 1'b0;
						dirty_first_q <= '0;
						dirty_last_q  <= '0;
					end
				end
				mfdlp_pkg::OP_REDRAW: begin
					dirty_flag_q  <= 1'b1;
					dirty_first_q <= '0;
					dirty_last_q  <= LINE_W'(SCREEN_HEIGHT - 1);
				end
				default: begin
				end
			endcase
		end
	end

	// frame accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cfg.clear_acc) begin
			acc_q <= '0;
		end else if (ctl.adv3 && (op_s2 == mfdlp_pkg::OP_TICK)) begin
			acc_q <= reach ? after_sub : sum_sat;
		end
	end

	// checks on the dirty range
	`MFDLP_ASSERT_IMPLIES(a_clean_range_zero, !dirty_flag_q, (dirty_first_q == '0) && (dirty_last_q == '0))
	`MFDLP_ASSERT_IMPLIES(a_dirty_first_on_screen, dirty_flag_q, dirty_first_q < LINE_W'(SCREEN_HEIGHT))
	`MFDLP_ASSERT_NEXT(a_flush_clears_range, ctl.adv3 && fire && !cfg.mark_all, !dirty_flag_q)

endmodule

[hdl/mono_framebuffer_dirty_line_pacer.sv]
// Top level of the monochrome frame buffer with dirty line pacing
// Depends on mfdlp_pkg, mfdlp_vram, mfdlp_pacer and the assertion macro header
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  item     | item_valid / item_stall    | operation address access_size write_data tick_count
//  result   | result_valid / result_stall| read_data flush_valid flush_first_line flush_line_count
//  config   | psel penable pwrite pready | paddr pwdata prdata
//
// One item per cycle sustained while the result is not stalled; each item passes the stages in order.
// The stages are input register, video RAM read plus line numbers, and result register;
// the dirty range and frame accumulator are updated as the item enters the result register.
// A stalled result holds the pipeline; item_stall rises only when all three stages are full.
// Reset clears control and sets the whole screen dirty; video RAM is not cleared.
`include "mono_framebuffer_dirty_line_pacer_macros.svh"

module mono_framebuffer_dirty_line_pacer #(
	parameter int RAM_BYTES     = 262144,
	parameter int SCREEN_WIDTH  = 1280,
	parameter int SCREEN_HEIGHT = 960,
	parameter int FRAME_RATE    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          operation,
	input  logic [mfdlp_pkg::ADDR_W-1:0]        address,
	input  logic [1:0]                          access_size,
	input  logic [mfdlp_pkg::DATA_W-1:0]        write_data,
	input  logic [mfdlp_pkg::COUNT_W-1:0]       tick_count,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [mfdlp_pkg::DATA_W-1:0]        read_data,
	output logic                                flush_valid,
	output logic [mfdlp_pkg::LINE_OUT_W-1:0]    flush_first_line,
	output logic [mfdlp_pkg::LINE_OUT_W-1:0]    flush_line_count,
	// configuration bus
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	logic                                v_s1;
	logic                                v_s2;
	logic                                valid_q;
	logic                                free_out;
	logic                                s2_free;
	logic                                s1_free;
	logic                                accept;

	mfdlp_pkg::op_t                      op_s1;
	logic [mfdlp_pkg::ADDR_W-1:0]        addr_s1;
	logic [1:0]                          size_s1;
	logic [mfdlp_pkg::DATA_W-1:0]        data_s1;
	logic [mfdlp_pkg::COUNT_W-1:0]       count_s1;

	mfdlp_pkg::op_t                      op_s2;
	logic [1:0]                          lo_s2;
	logic [1:0]                          size_s2;

	logic [mfdlp_pkg::DATA_W-1:0]        read_data_q;
	logic                                flush_valid_q;
	logic [mfdlp_pkg::LINE_OUT_W-1:0]    flush_first_line_q;
	logic [mfdlp_pkg::LINE_OUT_W-1:0]    flush_line_count_q;

	logic [mfdlp_pkg::RATE_W-1:0]        rate_q;
	logic                                attached_q;
	logic                                cfg_wr;

	mfdlp_pkg::pipe_ctl_t                ctl;
	mfdlp_pkg::cfg_t                     cfg;
	mfdlp_pkg::flush_t                   flush;
	logic [mfdlp_pkg::DATA_W-1:0]        rd_data;

	// pipeline flow control, each stage moves when the next one is free
	assign free_out   = !valid_q || !result_stall;
	assign ctl.adv3   = v_s2 && free_out;
	assign s2_free    = !v_s2 || ctl.adv3;
	assign ctl.adv2   = v_s1 && s2_free;
	assign s1_free    = !v_s1 || ctl.adv2;
	assign accept     = item_valid && s1_free;
	assign item_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= item_valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (free_out) begin
				valid_q <= v_s2;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= mfdlp_pkg::op_t'(operation);
			addr_s1  <= address;
			size_s1  <= access_size;
			data_s1  <= write_data;
			count_s1 <= tick_count;
		end
	end

	// second stage fields for read assembly and state update
	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			op_s2   <= op_s1;
			lo_s2   <= addr_s1[1:0];
			size_s2 <= size_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			read_data_q        <= rd_data;
			flush_valid_q      <= flush.valid;
			flush_first_line_q <= flush.first_line;
			flush_line_count_q <= flush.line_count;
		end
	end

	assign result_valid     = valid_q;
	assign read_data        = read_data_q;
	assign flush_valid      = flush_valid_q;
	assign flush_first_line = flush_first_line_q;
	assign flush_line_count = flush_line_count_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= mfdlp_pkg::RATE_RESET;
			attached_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				mfdlp_pkg::REG_CLOCK_RATE: rate_q     <= pwdata[mfdlp_pkg::RATE_W-1:0];
				mfdlp_pkg::REG_DISPLAY:    attached_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mfdlp_pkg::REG_CLOCK_RATE: prdata = 32'(rate_q);
			mfdlp_pkg::REG_DISPLAY:    prdata = {31'd0, attached_q};
			default:                   prdata = '0;
		endcase
	end

	// write side effects: new rate clears the accumulator, attaching redraws all
	always_comb begin
		cfg.rate      = rate_q;
		cfg.attached  = attached_q;
		cfg.clear_acc = cfg_wr && (paddr[2] == mfdlp_pkg::REG_CLOCK_RATE);
		cfg.mark_all  = cfg_wr && (paddr[2] == mfdlp_pkg::REG_DISPLAY) && pwdata[0];
	end

	// video RAM
	mfdlp_vram #(
		.RAM_BYTES(RAM_BYTES)
	) u_vram (
		.clk    (clk),
		.en     (ctl.adv2),
		.op_s1  (op_s1),
		.addr_s1(addr_s1),
		.size_s1(size_s1),
		.data_s1(data_s1),
		.op_s2  (op_s2),
		.lo_s2  (lo_s2),
		.size_s2(size_s2),
		.rd_data(rd_data)
	);

	// dirty tracking and frame pacing
	mfdlp_pacer #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.FRAME_RATE   (FRAME_RATE)
	) u_pacer (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cfg     (cfg),
		.addr_s1 (addr_s1),
		.size_s1 (size_s1),
		.count_s1(count_s1),
		.op_s2   (op_s2),
		.flush   (flush)
	);

	// pipeline checks
	`MFDLP_ASSERT_IMPLIES(a_empty_input_accepts, !v_s1, !item_stall)
	`MFDLP_ASSERT_IMPLIES(a_full_pipe_holds, v_s1 && v_s2 && valid_q && result_stall, item_stall)
	`MFDLP_ASSERT_IMPLIES(a_quiet_flush_fields, valid_q && !flush_valid_q, (flush_first_line_q == '0) && (flush_line_count_q == '0))

endmodule
